### src/tts_pkg.sv
package tts_pkg;

   localparam int unsigned TAG_W     = 8;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned PEND_W    = 8;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned RES_LIMIT = 8;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_TICK     = 2'd1,
      OP_DISPATCH = 2'd2,
      OP_DELETE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_REJECT = 2'd1,
      ST_DUE    = 2'd2,
      ST_NONE   = 2'd3
   } status_type;

   // command handed from the front queue to the back engine
   typedef struct packed {
      op_type               op;
      logic [TAG_W-1:0]     tag;
      logic [TIME_W-1:0]    delay;
      logic [TIME_W-1:0]    period;
      logic [2:0]           index;
   } cmd_type;

   typedef struct packed {
      status_type           status;
      logic [TAG_W-1:0]     tag;
      logic                 last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_SHIFT,
      S_EMIT
   } eng_state_type;

endpackage

### src/tts_front.sv
// Two-entry command queue between the request port and the engine.
module tts_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tts_pkg::cmd_type  in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output tts_pkg::cmd_type  out_cmd
);

   tts_pkg::cmd_type q_ff [2];
   tts_pkg::cmd_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = q_ff[0];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) begin
            q_in[0] = in_cmd;
         end else if (cnt_ff == 2'd1 || pop) begin
            q_in[1] = in_cmd;
         end
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

### src/tts_engine.sv
// Slot table and the engine that walks it one slot per cycle, unless a due report waits for the result register.
module tts_engine #(
   parameter int unsigned MAX_TASKS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  tts_pkg::cmd_type  cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tts_pkg::rsp_type  rsp
);

   localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int unsigned CW = $clog2(MAX_TASKS + 1);
   localparam int unsigned NW = $clog2(tts_pkg::RES_LIMIT + 1);

   logic [tts_pkg::TAG_W-1:0]  tag_ff    [MAX_TASKS];
   logic [tts_pkg::TIME_W-1:0] delay_ff  [MAX_TASKS];
   logic [tts_pkg::TIME_W-1:0] period_ff [MAX_TASKS];
   logic [tts_pkg::PEND_W-1:0] pend_ff   [MAX_TASKS];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;      // walk or shift position
   logic [NW-1:0] n_ff, n_in;          // due reports so far
   tts_pkg::eng_state_type state_ff, state_in;
   tts_pkg::op_type op_ff, op_in;
   tts_pkg::rsp_type out_ff, out_in;
   logic out_vld_ff, out_vld_in;
   tts_pkg::rsp_type hold_ff, hold_in; // due report waiting for its last flag
   logic hold_vld_ff, hold_vld_in;
   logic resume_shift_ff, resume_shift_in;
   // resume position after a one-shot removal: the shift leaves pos at the
   // old end, so the removal point is kept separately
   logic [CW-1:0] rm_pos_ff;

   logic [IW-1:0] pidx, pidx1;
   logic          start, out_free;
   logic          wr_add, wr_tick, wr_dec, wr_shift;

   assign pidx  = pos_ff[IW-1:0];
   assign pidx1 = IW'(pos_ff + CW'(1));
   assign out_free = !out_vld_ff || rsp_ready;
   assign rsp_valid = out_vld_ff;
   assign rsp = out_ff;
   assign cmd_ready = (state_ff == tts_pkg::S_IDLE) && out_free;
   assign start = cmd_valid && cmd_ready;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      n_in = n_ff;
      op_in = op_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      hold_in = hold_ff;
      hold_vld_in = hold_vld_ff;
      resume_shift_in = resume_shift_ff;
      wr_add = 1'b0;
      wr_tick = 1'b0;
      wr_dec = 1'b0;
      wr_shift = 1'b0;
      case (state_ff)
         tts_pkg::S_IDLE: begin
            if (start) begin
               op_in = cmd.op;
               pos_in = '0;
               n_in = '0;
               hold_vld_in = 1'b0;
               case (cmd.op)
                  tts_pkg::OP_ADD: begin
                     out_vld_in = 1'b1;
                     out_in = '{tts_pkg::ST_OK, '0, 1'b1};
                     if (count_ff >= CW'(MAX_TASKS)) begin
                        out_in.status = tts_pkg::ST_REJECT;
                     end else begin
                        wr_add = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  tts_pkg::OP_TICK: begin
                     state_in = tts_pkg::S_WALK;
                  end
                  tts_pkg::OP_DISPATCH: begin
                     state_in = tts_pkg::S_WALK;
                  end
                  tts_pkg::OP_DELETE: begin
                     if (CW'(cmd.index) >= count_ff || 32'(cmd.index) >= MAX_TASKS) begin
                        out_vld_in = 1'b1;
                        out_in = '{tts_pkg::ST_REJECT, '0, 1'b1};
                     end else begin
                        pos_in = CW'(cmd.index);
                        resume_shift_in = 1'b0;
                        state_in = tts_pkg::S_SHIFT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         tts_pkg::S_WALK: begin
            if (op_ff == tts_pkg::OP_TICK) begin
               if (pos_ff < count_ff) begin
                  wr_tick = 1'b1;
                  pos_in = pos_ff + CW'(1);
               end else begin
                  out_in = '{tts_pkg::ST_OK, '0, 1'b1};
                  state_in = tts_pkg::S_EMIT;
               end
            end else if (pos_ff < count_ff && n_ff < NW'(tts_pkg::RES_LIMIT)) begin
               if (pend_ff[pidx] != '0) begin
                  // previous report must leave before this one is held
                  if (!hold_vld_ff || out_free) begin
                     if (hold_vld_ff) begin
                        out_vld_in = 1'b1;
                        out_in = hold_ff;
                     end
                     hold_vld_in = 1'b1;
                     hold_in = '{tts_pkg::ST_DUE, tag_ff[pidx], 1'b0};
                     n_in = n_ff + NW'(1);
                     wr_dec = 1'b1;
                     if (period_ff[pidx] == '0) begin
                        resume_shift_in = 1'b1;
                        state_in = tts_pkg::S_SHIFT;
                     end else begin
                        pos_in = pos_ff + CW'(1);
                     end
                  end
               end else begin
                  pos_in = pos_ff + CW'(1);
               end
            end else if (out_free) begin
               // the result register may still hold an earlier report
               if (hold_vld_ff) begin
                  out_in = hold_ff;
                  out_in.last = 1'b1;
               end else begin
                  out_in = '{tts_pkg::ST_NONE, '0, 1'b1};
               end
               hold_vld_in = 1'b0;
               state_in = tts_pkg::S_EMIT;
            end
         end
         tts_pkg::S_SHIFT: begin
            if (pos_ff + CW'(1) < count_ff) begin
               wr_shift = 1'b1;
               pos_in = pos_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               if (resume_shift_ff) begin
                  pos_in = rm_pos_ff;
                  state_in = tts_pkg::S_WALK;
               end else begin
                  out_in = '{tts_pkg::ST_OK, '0, 1'b1};
                  state_in = tts_pkg::S_EMIT;
               end
            end
         end
         tts_pkg::S_EMIT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               state_in = tts_pkg::S_IDLE;
            end
         end
         default: state_in = tts_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == tts_pkg::S_WALK && wr_dec && period_ff[pidx] == '0) begin
         rm_pos_ff <= pos_ff;
      end else if (start) begin
         rm_pos_ff <= CW'(cmd.index);
      end
      if (wr_add) begin
         tag_ff[count_ff[IW-1:0]]    <= cmd.tag;
         delay_ff[count_ff[IW-1:0]]  <= cmd.delay;
         period_ff[count_ff[IW-1:0]] <= cmd.period;
         pend_ff[count_ff[IW-1:0]]   <= '0;
      end
      if (wr_tick) begin
         if (delay_ff[pidx] != '0) begin
            delay_ff[pidx] <= delay_ff[pidx] - tts_pkg::TIME_W'(1);
         end else begin
            delay_ff[pidx] <= period_ff[pidx];
            if (pend_ff[pidx] != '1) begin
               pend_ff[pidx] <= pend_ff[pidx] + tts_pkg::PEND_W'(1);
            end
         end
      end
      if (wr_dec) begin
         pend_ff[pidx] <= pend_ff[pidx] - tts_pkg::PEND_W'(1);
      end
      if (wr_shift) begin
         tag_ff[pidx]    <= tag_ff[pidx1];
         delay_ff[pidx]  <= delay_ff[pidx1];
         period_ff[pidx] <= period_ff[pidx1];
         pend_ff[pidx]   <= pend_ff[pidx1];
      end
      pos_ff <= pos_in;
      n_ff <= n_in;
      op_ff <= op_in;
      out_ff <= out_in;
      hold_ff <= hold_in;
      resume_shift_ff <= resume_shift_in;
      if (reset) begin
         state_ff <= tts_pkg::S_IDLE;
         count_ff <= '0;
         out_vld_ff <= 1'b0;
         hold_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         out_vld_ff <= out_vld_in;
         hold_vld_ff <= hold_vld_in;
      end
   end

endmodule

### src/tick_task_scheduler_table.sv
// Time-triggered task table. One request transfer on req_ is one operation:
// add a task, tick, dispatch, or delete a slot by position (op in req_tuser).
// Each operation answers on rsp_ with one or more transfers; rsp_tlast marks
// the final one. Add, tick and delete answer once with accepted or rejected.
// Dispatch answers once per slot with pending runs (status due, with its tag),
// up to 8 per dispatch, or once with "none due" when nothing is pending.
// A two-entry command queue takes requests while the engine works, so the
// request side stalls only when both entries are full.
// Each request is registered in the queue before it reaches the engine. Add
// and a rejected delete answer from the idle state through the result register.
// The engine visits one occupied slot per cycle while dispatch reports are not
// held up by the result register; tick answers once the walk is done, and each
// one-shot removal or delete shifts every later slot down by one.
// The engine starts the next operation only after the previous one is done.
// Reset empties the table and the queue; no clearing pass is needed.
// When the receiver holds rsp_tready low the result register holds its
// transfer and the engine waits; the queue keeps taking requests until full.
module tick_task_scheduler_table #(
   parameter int unsigned MAX_TASKS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // task_tag, start_delay, repeat_period, slot_index, pad
   input  logic [1:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // due_tag
   output logic [1:0]  rsp_tuser,  // status
   output logic        rsp_tlast
);

   tts_pkg::cmd_type in_cmd, q_cmd;
   tts_pkg::rsp_type rsp;
   logic q_valid, q_ready;

   assign in_cmd.op     = tts_pkg::op_type'(req_tuser);
   assign in_cmd.tag    = req_tdata[7:0];
   assign in_cmd.delay  = req_tdata[39:8];
   assign in_cmd.period = req_tdata[71:40];
   assign in_cmd.index  = req_tdata[74:72];

   tts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (in_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   tts_engine #(.MAX_TASKS(MAX_TASKS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = rsp.tag;
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

`ifndef SYNTHESIS
   a_tag_only_due: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != tts_pkg::ST_DUE |-> rsp_tdata == 8'd0)
      else $error("tag set on a non-due result");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tts_pkg::ST_OK || rsp_tuser == tts_pkg::ST_REJECT
         || rsp_tuser == tts_pkg::ST_NONE) |-> rsp_tlast)
      else $error("single result without tlast");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");
`endif

endmodule

### sim/tb_tick_task_scheduler_table.sv
`timescale 1ns / 100ps

module tb_tick_task_scheduler_table;

   localparam int NSLOTS = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      tts_pkg::status_type st;
      logic [7:0] tag;
      logic       lst;
   } sched_rsp_type;

   class sched_board_type;
      logic [7:0]  tag_q[NSLOTS];
      logic [31:0] dly_q[NSLOTS];
      logic [31:0] per_q[NSLOTS];
      logic [7:0]  pend_q[NSLOTS];
      int          used;
      sched_rsp_type pending_rsp[$];
      int          errors;
      int          n_due, n_reject, n_none;

      function new();
         used = 0;
         errors = 0;
         n_due = 0;
         n_reject = 0;
         n_none = 0;
      endfunction

      function void push(tts_pkg::status_type s, logic [7:0] t, logic l);
         sched_rsp_type r;
         r.st = s;
         r.tag = t;
         r.lst = l;
         pending_rsp.push_back(r);
      endfunction

      function void drop_slot(int p);
         for (int j = p; j + 1 < used; j++) begin
            tag_q[j] = tag_q[j+1];
            dly_q[j] = dly_q[j+1];
            per_q[j] = per_q[j+1];
            pend_q[j] = pend_q[j+1];
         end
         used--;
      endfunction

      // predict results of one accepted request
      function void note_request(tts_pkg::op_type op, logic [7:0] t, logic [31:0] d,
                                 logic [31:0] p, logic [2:0] idx);
         int i;
         int n;
         case (op)
            tts_pkg::OP_ADD: begin
               if (used >= NSLOTS) begin
                  push(tts_pkg::ST_REJECT, 0, 1);
                  n_reject++;
               end else begin
                  tag_q[used] = t;
                  dly_q[used] = d;
                  per_q[used] = p;
                  pend_q[used] = 0;
                  used++;
                  push(tts_pkg::ST_OK, 0, 1);
               end
            end
            tts_pkg::OP_TICK: begin
               for (i = 0; i < used; i++) begin
                  if (dly_q[i] != 0) dly_q[i]--;
                  else begin
                     dly_q[i] = per_q[i];
                     if (pend_q[i] != 8'hff) pend_q[i]++;
                  end
               end
               push(tts_pkg::ST_OK, 0, 1);
            end
            tts_pkg::OP_DISPATCH: begin
               n = 0;
               i = 0;
               while (i < used && n < tts_pkg::RES_LIMIT) begin
                  if (pend_q[i] != 0) begin
                     pend_q[i]--;
                     push(tts_pkg::ST_DUE, tag_q[i], 0);
                     n++;
                     n_due++;
                     if (per_q[i] == 0) begin
                        drop_slot(i);
                        continue;
                     end
                  end
                  i++;
               end
               if (n == 0) begin
                  push(tts_pkg::ST_NONE, 0, 1);
                  n_none++;
               end else pending_rsp[$].lst = 1;
            end
            default: begin
               if (idx >= used) begin
                  push(tts_pkg::ST_REJECT, 0, 1);
                  n_reject++;
               end else begin
                  drop_slot(idx);
                  push(tts_pkg::ST_OK, 0, 1);
               end
            end
         endcase
      endfunction

      function void check_result(logic [1:0] st, logic [7:0] t, logic l);
         sched_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result status=%0d tag=%0h last=%0b", $time, st, t, l);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (st !== e.st) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, e.st, st);
            errors++;
         end
         if (t !== e.tag) begin
            $display("%0t: due_tag mismatch expected %0h actual %0h", $time, e.tag, t);
            errors++;
         end
         if (l !== e.lst) begin
            $display("%0t: last mismatch expected %0b actual %0b", $time, e.lst, l);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   sched_board_type board;
   int  cycles;
   bit  hold_off;
   int  n_sent;

   tick_task_scheduler_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      cycles = 0;
      hold_off = 1'b0;
      n_sent = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_tick_task_scheduler_table failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // receiver stall pattern, with calm stretches and one long hold-off
   initial begin
      int phase;
      int k;
      phase = 0;
      @(posedge clock);
      while (1) begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            for (k = 0; k < 60; k++) @(posedge clock);
            hold_off = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            phase++;
            if ((phase / 64) % 3 == 0) rsp_tready <= 1'b1;
            else rsp_tready <= ($urandom_range(0, 99) < 65);
         end
      end
   end

   task automatic send(tts_pkg::op_type op, logic [7:0] t, logic [31:0] d, logic [31:0] p,
                       logic [2:0] idx);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {5'b0, idx, p, d, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, t, d, p, idx);
      n_sent++;
   endtask

   task automatic pause();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_time();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'hffff_ffff;
      if (r == 1) return $urandom();
      return $urandom_range(0, 4);
   endfunction

   task automatic send_random();
      int r;
      tts_pkg::op_type op;
      r = $urandom_range(0, 99);
      if (r < 25) op = tts_pkg::OP_ADD;
      else if (r < 60) op = tts_pkg::OP_TICK;
      else if (r < 85) op = tts_pkg::OP_DISPATCH;
      else op = tts_pkg::OP_DELETE;
      send(op, 8'($urandom()), rand_time(), rand_time(), 3'($urandom_range(0, 7)));
   endtask

   initial begin
      int burst;
      int k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, fill, overflow, extremes
      send(tts_pkg::OP_DISPATCH, 0, 0, 0, 0);
      send(tts_pkg::OP_DELETE, 0, 0, 0, 0);
      send(tts_pkg::OP_TICK, 0, 0, 0, 0);
      send(tts_pkg::OP_ADD, 8'h00, 32'd0, 32'd0, 0);
      send(tts_pkg::OP_ADD, 8'hff, 32'd1, 32'd0, 0);
      send(tts_pkg::OP_ADD, 8'h5a, 32'hffff_ffff, 32'hffff_ffff, 0);
      send(tts_pkg::OP_ADD, 8'ha5, 32'd0, 32'd1, 0);
      send(tts_pkg::OP_ADD, 8'h11, 32'd2, 32'd0, 0);
      send(tts_pkg::OP_ADD, 8'h22, 32'd0, 32'd2, 0);
      send(tts_pkg::OP_ADD, 8'h33, 32'd1, 32'd1, 0);
      send(tts_pkg::OP_ADD, 8'h44, 32'h8000_0000, 32'h7fff_ffff, 0);
      send(tts_pkg::OP_ADD, 8'h77, 0, 0, 0);
      send(tts_pkg::OP_DELETE, 0, 0, 0, 3'd7);
      send(tts_pkg::OP_TICK, 0, 0, 0, 0);
      send(tts_pkg::OP_TICK, 0, 0, 0, 0);
      send(tts_pkg::OP_DISPATCH, 0, 0, 0, 0);
      send(tts_pkg::OP_TICK, 0, 0, 0, 0);
      send(tts_pkg::OP_DISPATCH, 0, 0, 0, 0);
      send(tts_pkg::OP_DELETE, 0, 0, 0, 3'd0);
      send(tts_pkg::OP_DELETE, 0, 0, 0, 3'd7);
      pause();

      // pending counter saturation: period-0-delay slot due every tick
      while (board.used > 0) send(tts_pkg::OP_DELETE, 0, 0, 0, 3'd0);
      send(tts_pkg::OP_ADD, 8'hc3, 32'd0, 32'd0, 0);
      send(tts_pkg::OP_ADD, 8'h3c, 32'd0, 32'hffff_ffff, 0);
      send(tts_pkg::OP_ADD, 8'h96, 32'd0, 32'd0, 0);
      for (k = 0; k < 270; k++) begin
         // fast counter: period 0 after first reload stays at zero delay
         send(tts_pkg::OP_TICK, 0, 0, 0, 0);
         if (k == 100) hold_off = 1'b1;
      end
      send(tts_pkg::OP_DISPATCH, 0, 0, 0, 0);
      send(tts_pkg::OP_DISPATCH, 0, 0, 0, 0);
      while (board.used > 0) send(tts_pkg::OP_DELETE, 0, 0, 0, 3'($urandom_range(0, 7)));

      // random traffic in bursts
      while (n_sent < 480) begin
         burst = $urandom_range(1, 20);
         for (k = 0; k < burst; k++) send_random();
         if ($urandom_range(0, 2) != 0) pause();
      end
      req_tvalid <= 1'b0;

      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d requests: %0d due reports, %0d rejects, %0d empty dispatches",
               n_sent, board.n_due, board.n_reject, board.n_none);
      if (board.errors == 0 && board.pending_rsp.size() == 0)
         $display("tb_tick_task_scheduler_table passed");
      else
         $display("tb_tick_task_scheduler_table failed");
      $finish;
   end

endmodule
